[hdl/axis_angle_between_vectors_defines.svh]
// Assertion macros used by the checker file of the rotation axis/angle block.
// No dependencies; included by files that assert.
`ifndef AXIS_ANGLE_BETWEEN_VECTORS_DEFINES_SVH
`define AXIS_ANGLE_BETWEEN_VECTORS_DEFINES_SVH

// checked only out of reset
`define ABV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define ABV_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hdl/abv_pkg.sv]
// Constants, widths and helper functions for the rotation axis/angle block.
// No dependencies; imported by every module of the block.
package abv_pkg;

    localparam int UNIT_FRAC    = 30;
    localparam int AXIS_FRAC    = 14;
    localparam int CORDIC_STEPS = 17;
    localparam int SQ_STEPS     = 32;
    localparam int CW           = 48;   // CORDIC x/y width
    localparam int AW           = 20;   // CORDIC angle accumulator width

    localparam logic [63:0]          AXIS_EPS_SQ = 64'd1152922;
    localparam logic signed [AW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [16:0]          ANGLE_MAX   = 17'd25736;

    function automatic logic signed [AW-1:0] atan_q16(input int i);
        case (i)
            0:       return 20'sd51472;
            1:       return 20'sd30386;
            2:       return 20'sd16055;
            3:       return 20'sd8150;
            4:       return 20'sd4091;
            5:       return 20'sd2047;
            6:       return 20'sd1024;
            7:       return 20'sd512;
            8:       return 20'sd256;
            9:       return 20'sd128;
            10:      return 20'sd64;
            11:      return 20'sd32;
            12:      return 20'sd16;
            13:      return 20'sd8;
            14:      return 20'sd4;
            15:      return 20'sd2;
            default: return 20'sd1;
        endcase
    endfunction

    // magnitude of a two's complement word; -2^31 maps to 2^31
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(~v + 32'd1) : v;
    endfunction

    // left shift that brings the largest magnitude to at least 2^30
    function automatic logic [4:0] norm_shift(input logic [31:0] mx);
        logic [4:0] k;
        k = '0;
        for (int i = 0; i < 30; i++) begin
            if (mx[i]) k = 5'(30 - i);
        end
        if (mx[31] || mx[30]) k = '0;
        return k;
    endfunction

    // |v| / 2^30 rounded half away from zero
    function automatic logic [31:0] rnd30(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << 29)) >> 30;
        return m[31:0];
    endfunction

    // arithmetic shift right truncating toward zero
    function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                       input int s);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        m = m >> s;
        return v[CW-1] ? $signed(CW'(-m)) : $signed(m);
    endfunction

endpackage

[hdl/abv_sqrt_cell.sv]
// One digit step of a pipelined 64-bit integer square root.
// Depends on abv_pkg.
module abv_sqrt_cell #(
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [63:0]   in_v,
    input  logic [63:0]   in_r,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [63:0]   out_v,
    output logic [63:0]   out_r,
    output logic [SW-1:0] out_side
);
    import abv_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic          valid_reg;
    logic [63:0]   v_reg, r_reg, v_next, r_next, trial;
    logic [SW-1:0] side_reg;

    always_comb begin
        trial = in_r + BIT;
        if (in_v >= trial) begin
            v_next = in_v - trial;
            r_next = (in_r >> 1) + BIT;
        end else begin
            v_next = in_v;
            r_next = in_r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;
endmodule

[hdl/abv_div_cell.sv]
// One quotient bit of a pipelined restoring divider.
// Depends on abv_pkg.
module abv_div_cell #(
    parameter int NW   = 63,
    parameter int QW   = 31,
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_rem,
    input  logic [31:0]   in_den,
    input  logic [QW-1:0] in_quo,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_rem,
    output logic [31:0]   out_den,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);
    import abv_pkg::*;

    logic          valid_reg;
    logic [NW-1:0] rem_reg, rem_next, trial;
    logic [31:0]   den_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic [SW-1:0] side_reg;

    always_comb begin
        trial = NW'(in_den) << STEP;
        if (in_rem >= trial) begin
            rem_next = in_rem - trial;
            quo_next = in_quo | (QW'(1) << STEP);
        end else begin
            rem_next = in_rem;
            quo_next = in_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;
endmodule

[hdl/abv_cordic_cell.sv]
// One vectoring step of a pipelined CORDIC arctangent.
// Depends on abv_pkg.
module abv_cordic_cell #(
    parameter int STEP = 0,
    parameter int SW   = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [abv_pkg::CW-1:0] in_x,
    input  logic signed [abv_pkg::CW-1:0] in_y,
    input  logic signed [abv_pkg::AW-1:0] in_acc,
    input  logic [SW-1:0]                in_side,
    output logic                         out_valid,
    output logic signed [abv_pkg::CW-1:0] out_x,
    output logic signed [abv_pkg::CW-1:0] out_y,
    output logic signed [abv_pkg::AW-1:0] out_acc,
    output logic [SW-1:0]                out_side
);
    import abv_pkg::*;

    logic                 valid_reg;
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [SW-1:0]        side_reg;

    always_comb begin
        dx = shr_trunc(in_y, STEP);
        dy = shr_trunc(in_x, STEP);
        if (in_y > 0) begin
            x_next   = in_x + dx;
            y_next   = in_y - dy;
            acc_next = in_acc + atan_q16(STEP);
        end else begin
            x_next   = in_x - dx;
            y_next   = in_y + dy;
            acc_next = in_acc - atan_q16(STEP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
    assign out_side  = side_reg;
endmodule

[hdl/abv_unit.sv]
// Scales a 3-vector (magnitudes plus signs) to unit length with FRAC fraction bits.
// Depends on abv_pkg, abv_sqrt_cell and abv_div_cell.
module abv_unit #(
    parameter int FRAC = abv_pkg::UNIT_FRAC,
    parameter int SW   = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0][31:0]      in_mag,
    input  logic [2:0]            in_neg,
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output logic [2:0][FRAC+1:0]  out_val,
    output logic                  out_zero,
    output logic [SW-1:0]         out_side
);
    import abv_pkg::*;

    localparam int NW  = FRAC + 33;
    localparam int QW  = FRAC + 1;
    localparam int SQW = 96 + 3 + 1 + SW;
    localparam int DSW = 2 + SW;
    localparam logic [QW-1:0] LIM = QW'(1) << FRAC;

    // front: capture, shift search, shift, squares, sum
    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [2:0][31:0] mag1_reg, mag2_reg, m3_reg, m4_reg, m5_reg;
    logic [2:0]       neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic             zero2_reg, zero3_reg, zero4_reg, zero5_reg;
    logic [SW-1:0]    side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    logic [4:0]       k2_reg;
    logic [2:0][63:0] sq4_reg;
    logic [63:0]      s5_reg;
    logic [31:0]      mx;

    always_comb begin
        mx = mag1_reg[0];
        if (mag1_reg[1] > mx) mx = mag1_reg[1];
        if (mag1_reg[2] > mx) mx = mag1_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= in_mag;
            neg1_reg  <= in_neg;
            side1_reg <= in_side;

            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            side2_reg <= side1_reg;
            k2_reg    <= norm_shift(mx);
            zero2_reg <= (mx == 32'd0);

            for (int i = 0; i < 3; i++) begin
                m3_reg[i] <= mag2_reg[i] << k2_reg;
            end
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
            side3_reg <= side2_reg;

            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= {32'd0, m3_reg[i]} * {32'd0, m3_reg[i]};
            end
            m4_reg    <= m3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            side4_reg <= side3_reg;

            s5_reg    <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
            m5_reg    <= m4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            side5_reg <= side4_reg;
        end
    end

    // norm = floor(sqrt(sum of squares)), one root bit per cell
    logic           qval [SQ_STEPS+1];
    logic [63:0]    qv   [SQ_STEPS+1];
    logic [63:0]    qr   [SQ_STEPS+1];
    logic [SQW-1:0] qs   [SQ_STEPS+1];

    assign qval[0] = v5_reg;
    assign qv[0]   = s5_reg;
    assign qr[0]   = '0;
    assign qs[0]   = {m5_reg, neg5_reg, zero5_reg, side5_reg};

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        abv_sqrt_cell #(.STEP(g), .SW(SQW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (qval[g]),
            .in_v      (qv[g]),
            .in_r      (qr[g]),
            .in_side   (qs[g]),
            .out_valid (qval[g+1]),
            .out_v     (qv[g+1]),
            .out_r     (qr[g+1]),
            .out_side  (qs[g+1])
        );
    end

    // dividend = (m << FRAC) + n/2
    logic [2:0][31:0]   qm;
    logic [2:0]         qneg;
    logic               qzero;
    logic [SW-1:0]      qside;
    logic [31:0]        nrm;
    logic [2:0][NW-1:0] num6_reg;
    logic [31:0]        n6_reg;
    logic [2:0]         neg6_reg;
    logic               zero6_reg;
    logic [SW-1:0]      side6_reg;

    assign {qm, qneg, qzero, qside} = qs[SQ_STEPS];
    assign nrm = qr[SQ_STEPS][31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= qval[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num6_reg[i] <= (NW'(qm[i]) << FRAC) + NW'(nrm >> 1);
            end
            n6_reg    <= nrm;
            neg6_reg  <= qneg;
            zero6_reg <= qzero;
            side6_reg <= qside;
        end
    end

    // three divider lanes, one quotient bit per cell, MSB first
    logic           dval [3][QW+1];
    logic [NW-1:0]  drem [3][QW+1];
    logic [31:0]    dden [3][QW+1];
    logic [QW-1:0]  dquo [3][QW+1];
    logic [DSW-1:0] dsd  [3][QW+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign dval[l][0] = v6_reg;
        assign drem[l][0] = num6_reg[l];
        assign dden[l][0] = n6_reg;
        assign dquo[l][0] = '0;
        assign dsd[l][0]  = {neg6_reg[l], zero6_reg, side6_reg};
        for (genvar j = 0; j < QW; j++) begin : g_bit
            abv_div_cell #(.NW(NW), .QW(QW), .STEP(QW - 1 - j), .SW(DSW)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (dval[l][j]),
                .in_rem    (drem[l][j]),
                .in_den    (dden[l][j]),
                .in_quo    (dquo[l][j]),
                .in_side   (dsd[l][j]),
                .out_valid (dval[l][j+1]),
                .out_rem   (drem[l][j+1]),
                .out_den   (dden[l][j+1]),
                .out_quo   (dquo[l][j+1]),
                .out_side  (dsd[l][j+1])
            );
        end
    end

    // saturate and apply sign
    logic                  ovalid_reg;
    logic [2:0][FRAC+1:0]  oval_reg, oval_next;
    logic                  ozero_reg;
    logic [SW-1:0]         oside_reg;
    logic [QW-1:0]         qsat [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qsat[i] = (dquo[i][QW] > LIM) ? LIM : dquo[i][QW];
            oval_next[i] = dsd[i][QW][DSW-1] ? (FRAC+2)'(~{1'b0, qsat[i]} + 1'b1)
                                             : {1'b0, qsat[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (en) begin
            ovalid_reg <= dval[0][QW] & dval[1][QW] & dval[2][QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oval_reg  <= oval_next;
            ozero_reg <= dsd[0][QW][SW];
            oside_reg <= dsd[0][QW][SW-1:0];
        end
    end

    assign out_valid = ovalid_reg;
    assign out_val   = oval_reg;
    assign out_zero  = ozero_reg;
    assign out_side  = oside_reg;
endmodule

[hdl/axis_angle_between_vectors.sv]
// Rotation axis and angle between an effector and a target vector (Q16.16 in,
// Q1.14 axis and UQ2.13 angle out). Fully pipelined: one word is taken every cycle
// unless the output stalls; each result passes through a chain of cells: two
// unit-vector stages (32-step root, 31-step divide), cross/dot product, rounding,
// square and sum registers, an axis normalizer, a 32-step root of the cross norm
// and a 17-step CORDIC arc tangent. When the output word is held by m_ready low
// the whole pipeline holds; s_ready = !m_valid || m_ready. status 1 flags a zero
// vector or parallel/opposite vectors, with axis and angle forced to zero.
module axis_angle_between_vectors (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_effector_x,
    input  logic signed [31:0] s_effector_y,
    input  logic signed [31:0] s_effector_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_axis_x,
    output logic signed [15:0] m_axis_y,
    output logic signed [15:0] m_axis_z,
    output logic [14:0]        m_angle,
    output logic               m_status
);
    import abv_pkg::*;

    localparam int UVW = UNIT_FRAC + 2;
    localparam int AXW = AXIS_FRAC + 2;
    localparam int XSW = 64 + 32 + 1;
    localparam int RSW = 3 * AXW + 32 + 1;
    localparam int KSW = 3 * AXW + 1;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // unit vectors of both inputs
    logic                e_valid, e_zero, t_zero;
    logic [2:0][UVW-1:0] e_val, t_val;

    abv_unit #(.FRAC(UNIT_FRAC), .SW(1)) u_eff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_mag    ({mag32(s_effector_z), mag32(s_effector_y), mag32(s_effector_x)}),
        .in_neg    ({s_effector_z[31], s_effector_y[31], s_effector_x[31]}),
        .in_side   (1'b0),
        .out_valid (e_valid),
        .out_val   (e_val),
        .out_zero  (e_zero),
        .out_side  ()
    );

    abv_unit #(.FRAC(UNIT_FRAC), .SW(1)) u_tgt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_mag    ({mag32(s_target_z), mag32(s_target_y), mag32(s_target_x)}),
        .in_neg    ({s_target_z[31], s_target_y[31], s_target_x[31]}),
        .in_side   (1'b0),
        .out_valid (),
        .out_val   (t_val),
        .out_zero  (t_zero),
        .out_side  ()
    );

    logic signed [UVW-1:0] eu [3];
    logic signed [UVW-1:0] tu [3];
    for (genvar i = 0; i < 3; i++) begin : g_uv
        assign eu[i] = $signed(e_val[i]);
        assign tu[i] = $signed(t_val[i]);
    end

    // products, then rounding, then squared cross norm
    logic               vp_reg, vr_reg, vq1_reg, vq2_reg;
    logic signed [63:0] p_reg [9];
    logic               degp_reg, degr_reg, degq1_reg, degq2_reg;
    logic signed [63:0] cdiff [3];
    logic signed [63:0] dsum;
    logic [31:0]        dmag, dclamp;
    logic [2:0][31:0]   cm_reg, cm1_reg, cm2_reg;
    logic [2:0]         cneg_reg, cneg1_reg, cneg2_reg;
    logic signed [31:0] dot_reg, dot1_reg, dot2_reg;
    logic [63:0]        csq1_reg [3];
    logic [63:0]        csq2_reg, csq_sum;

    always_comb begin
        cdiff[0] = p_reg[0] - p_reg[1];
        cdiff[1] = p_reg[2] - p_reg[3];
        cdiff[2] = p_reg[4] - p_reg[5];
        dsum     = p_reg[6] + p_reg[7] + p_reg[8];
        dmag     = rnd30(dsum);
        dclamp   = (dmag > (32'd1 << UNIT_FRAC)) ? (32'd1 << UNIT_FRAC) : dmag;
        csq_sum  = csq1_reg[0] + csq1_reg[1] + csq1_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg  <= 1'b0;
            vr_reg  <= 1'b0;
            vq1_reg <= 1'b0;
            vq2_reg <= 1'b0;
        end else if (en) begin
            vp_reg  <= e_valid;
            vr_reg  <= vp_reg;
            vq1_reg <= vr_reg;
            vq2_reg <= vq1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= eu[1] * tu[2];
            p_reg[1] <= eu[2] * tu[1];
            p_reg[2] <= eu[2] * tu[0];
            p_reg[3] <= eu[0] * tu[2];
            p_reg[4] <= eu[0] * tu[1];
            p_reg[5] <= eu[1] * tu[0];
            p_reg[6] <= eu[0] * tu[0];
            p_reg[7] <= eu[1] * tu[1];
            p_reg[8] <= eu[2] * tu[2];
            degp_reg <= e_zero | t_zero;

            for (int i = 0; i < 3; i++) begin
                cm_reg[i]   <= rnd30(cdiff[i]);
                cneg_reg[i] <= cdiff[i][63];
            end
            dot_reg  <= dsum[63] ? $signed(32'(~dclamp + 32'd1)) : $signed(dclamp);
            degr_reg <= degp_reg;

            for (int i = 0; i < 3; i++) begin
                csq1_reg[i] <= {32'd0, cm_reg[i]} * {32'd0, cm_reg[i]};
            end
            cm1_reg   <= cm_reg;
            cneg1_reg <= cneg_reg;
            dot1_reg  <= dot_reg;
            degq1_reg <= degr_reg;

            csq2_reg  <= csq_sum;
            cm2_reg   <= cm1_reg;
            cneg2_reg <= cneg1_reg;
            dot2_reg  <= dot1_reg;
            degq2_reg <= degq1_reg | (csq_sum < AXIS_EPS_SQ);
        end
    end

    // unit axis from the rounded cross product
    logic                ax_valid, ax_zero;
    logic [2:0][AXW-1:0] ax_val;
    logic [XSW-1:0]      ax_side;
    logic [63:0]         ax_csq;
    logic [31:0]         ax_dot;
    logic                ax_deg;

    abv_unit #(.FRAC(AXIS_FRAC), .SW(XSW)) u_axis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vq2_reg),
        .in_mag    (cm2_reg),
        .in_neg    (cneg2_reg),
        .in_side   ({csq2_reg, dot2_reg, degq2_reg}),
        .out_valid (ax_valid),
        .out_val   (ax_val),
        .out_zero  (ax_zero),
        .out_side  (ax_side)
    );

    assign {ax_csq, ax_dot, ax_deg} = ax_side;

    // |cross| = floor(sqrt(csq))
    logic           rval [SQ_STEPS+1];
    logic [63:0]    rv   [SQ_STEPS+1];
    logic [63:0]    rr   [SQ_STEPS+1];
    logic [RSW-1:0] rs   [SQ_STEPS+1];

    assign rval[0] = ax_valid;
    assign rv[0]   = ax_csq;
    assign rr[0]   = '0;
    assign rs[0]   = {ax_val, ax_dot, ax_deg | ax_zero};

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_csqrt
        abv_sqrt_cell #(.STEP(g), .SW(RSW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (rval[g]),
            .in_v      (rv[g]),
            .in_r      (rr[g]),
            .in_side   (rs[g]),
            .out_valid (rval[g+1]),
            .out_v     (rv[g+1]),
            .out_r     (rr[g+1]),
            .out_side  (rs[g+1])
        );
    end

    // CORDIC entry: a negative dot is turned by -pi/2 first
    logic [3*AXW-1:0]     r_axis;
    logic [31:0]          r_dot;
    logic                 r_deg;
    logic signed [CW-1:0] r_dx, r_nm;
    logic                 vk_reg;
    logic signed [CW-1:0] kx_reg, ky_reg;
    logic signed [AW-1:0] kacc_reg;
    logic [KSW-1:0]       kside_reg;

    assign {r_axis, r_dot, r_deg} = rs[SQ_STEPS];
    assign r_dx = $signed({{(CW-32){r_dot[31]}}, r_dot});
    assign r_nm = $signed({{(CW-33){1'b0}}, rr[SQ_STEPS][32:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vk_reg <= 1'b0;
        end else if (en) begin
            vk_reg <= rval[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (r_dx < 0) begin
                kx_reg   <= r_nm;
                ky_reg   <= -r_dx;
                kacc_reg <= HALF_PI_Q16;
            end else begin
                kx_reg   <= r_dx;
                ky_reg   <= r_nm;
                kacc_reg <= '0;
            end
            kside_reg <= {r_axis, r_deg};
        end
    end

    logic                 cval [CORDIC_STEPS+1];
    logic signed [CW-1:0] cx   [CORDIC_STEPS+1];
    logic signed [CW-1:0] cy   [CORDIC_STEPS+1];
    logic signed [AW-1:0] cacc [CORDIC_STEPS+1];
    logic [KSW-1:0]       cs   [CORDIC_STEPS+1];

    assign cval[0] = vk_reg;
    assign cx[0]   = kx_reg;
    assign cy[0]   = ky_reg;
    assign cacc[0] = kacc_reg;
    assign cs[0]   = kside_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        abv_cordic_cell #(.STEP(g), .SW(KSW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cval[g]),
            .in_x      (cx[g]),
            .in_y      (cy[g]),
            .in_acc    (cacc[g]),
            .in_side   (cs[g]),
            .out_valid (cval[g+1]),
            .out_x     (cx[g+1]),
            .out_y     (cy[g+1]),
            .out_acc   (cacc[g+1]),
            .out_side  (cs[g+1])
        );
    end

    // Q.16 to UQ2.13 with clamps, output word register
    logic [2:0][AXW-1:0] f_axis;
    logic                f_deg;
    logic [AW-1:0]       f_pos;
    logic [16:0]         f_rnd, f_ang;
    logic                ovalid_reg, ostat_reg;
    logic [2:0][AXW-1:0] oaxis_reg;
    logic [14:0]         oang_reg;

    always_comb begin
        {f_axis, f_deg} = cs[CORDIC_STEPS];
        f_pos = cacc[CORDIC_STEPS][AW-1] ? '0 : cacc[CORDIC_STEPS];
        f_rnd = 17'((f_pos + AW'(4)) >> 3);
        f_ang = (f_rnd > ANGLE_MAX) ? ANGLE_MAX : f_rnd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (en) begin
            ovalid_reg <= cval[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oaxis_reg <= f_deg ? '0 : f_axis;
            oang_reg  <= f_deg ? '0 : f_ang[14:0];
            ostat_reg <= f_deg;
        end
    end

    assign m_valid  = ovalid_reg;
    assign m_axis_x = $signed(oaxis_reg[0]);
    assign m_axis_y = $signed(oaxis_reg[1]);
    assign m_axis_z = $signed(oaxis_reg[2]);
    assign m_angle  = oang_reg;
    assign m_status = ostat_reg;
endmodule

[hdl/abv_checker.sv]
// Port-level checks for the rotation axis/angle block, bound to its top level.
// Depends on axis_angle_between_vectors_defines.svh.
`include "axis_angle_between_vectors_defines.svh"

module abv_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_axis_x,
    input logic signed [15:0] m_axis_y,
    input logic signed [15:0] m_axis_z,
    input logic [14:0]        m_angle,
    input logic               m_status
);
    logic word_zero;
    assign word_zero = (m_axis_x == 16'sd0) && (m_axis_y == 16'sd0)
                    && (m_axis_z == 16'sd0) && (m_angle == 15'd0);

    `ABV_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "output word valid after reset")
    `ABV_ASSERT(a_ready_follow, s_ready == (!m_valid || m_ready), "s_ready not tied to output")
    `ABV_ASSERT(a_degen_zero, m_valid && m_status |-> word_zero, "degenerate word not zeroed")
    `ABV_ASSERT(a_angle_max, m_valid && !m_status |-> m_angle <= 15'd25736, "angle beyond pi")
    `ABV_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_angle) && $stable(m_status), "stalled word changed")
endmodule

bind axis_angle_between_vectors abv_checker u_abv_checker (.*);
